FILE: hw/rtl/clss_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// clss_pkg
// Shared types and constants of the control link safety supervisor: event
// codes, mode and reason codes, register indexes and the word structs.
// ============================================================================
package clss_pkg;

   // Field widths
   localparam int CMD_W     = 3;
   localparam int TSTAT_W   = 2;
   localparam int MODE_W    = 2;
   localparam int REASON_W  = 3;
   localparam int TIMEOUT_W = 16;
   localparam int RATE_W    = 10;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 16;

   // Event codes
   localparam logic [CMD_W-1:0] CMD_TICK     = 3'd0;
   localparam logic [CMD_W-1:0] CMD_SENSOR   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_TARGET   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_VELOCITY = 3'd3;
   localparam logic [CMD_W-1:0] CMD_RESUME   = 3'd4;
   localparam logic [CMD_W-1:0] CMD_OBS_TICK = 3'd5;
   localparam logic [CMD_W-1:0] CMD_CMD_TICK = 3'd6;

   // Target status codes
   localparam logic [TSTAT_W-1:0] TSTAT_VALID     = 2'd0;
   localparam logic [TSTAT_W-1:0] TSTAT_NONFINITE = 2'd2;

   // Modes
   localparam logic [MODE_W-1:0] MODE_WAIT_SENSOR = 2'd0;
   localparam logic [MODE_W-1:0] MODE_WAIT_POLICY = 2'd1;
   localparam logic [MODE_W-1:0] MODE_RUNNING     = 2'd2;
   localparam logic [MODE_W-1:0] MODE_DEGRADED    = 2'd3;

   // Degrade reasons
   localparam logic [REASON_W-1:0] WHY_NONE      = 3'd0;
   localparam logic [REASON_W-1:0] WHY_NONFINITE = 3'd1;
   localparam logic [REASON_W-1:0] WHY_SENSOR    = 3'd2;
   localparam logic [REASON_W-1:0] WHY_RATE      = 3'd3;
   localparam logic [REASON_W-1:0] WHY_TARGET    = 3'd4;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SENSOR_TIMEOUT   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TARGET_TIMEOUT   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_VELOCITY_TIMEOUT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_OBS_RATE     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_TICKS     = 3'd4;

   // Register reset values
   localparam logic [TIMEOUT_W-1:0] SENSOR_TIMEOUT_RST   = 16'd100;
   localparam logic [TIMEOUT_W-1:0] TARGET_TIMEOUT_RST   = 16'd60;
   localparam logic [TIMEOUT_W-1:0] VELOCITY_TIMEOUT_RST = 16'd500;
   localparam logic [RATE_W-1:0]    MIN_OBS_RATE_RST     = 10'd45;
   localparam logic [TIMEOUT_W-1:0] WINDOW_TICKS_RST     = 16'd1000;

   // Slow window counting
   localparam logic [1:0] SLOW_COUNT_MAX    = 2'd3;
   localparam logic [1:0] SLOW_WINDOW_LIMIT = 2'd3;

   typedef struct packed {
      logic [TIMEOUT_W-1:0] sensor_timeout;
      logic [TIMEOUT_W-1:0] target_timeout;
      logic [TIMEOUT_W-1:0] velocity_timeout;
      logic [RATE_W-1:0]    min_obs_rate;
      logic [TIMEOUT_W-1:0] window_ticks;
   } cfg_type;

   typedef struct packed {
      logic [CMD_W-1:0]   command;
      logic [TSTAT_W-1:0] target_status;
      logic               resume_value;
   } req_type;

   typedef struct packed {
      logic [MODE_W-1:0]   mode;
      logic                send_command;
      logic                drive;
      logic                use_velocity;
      logic                frame_valid;
      logic                hist_clear;
      logic [REASON_W-1:0] degrade_reason;
      logic                status_changed;
   } rsp_type;

endpackage

FILE: hw/rtl/control_link_safety_supervisor.sv
`timescale 1ns / 1ps
// ============================================================================
// control_link_safety_supervisor
// Safety supervisor for a robot control link. Events come in on the req_
// stream, one result word per event leaves on the rsp_ stream.
//
// The req_ channel carries one event per word: req_tuser holds the event
// code, req_tdata holds the target status and the resume flag. Each event
// yields exactly one rsp_ word with the mode, the send, drive, velocity and
// frame flags, the policy reset pulse, the degrade reason and a mode change
// flag. The csr_ port writes the timeouts, the minimum observation rate and
// the window length; write it only while no event is in flight.
// An accepted word is latched in the input register; the update runs from
// it and its result is loaded into the output register, raising rsp_tvalid,
// once that register is free or draining. One event is accepted every cycle
// while the receiver takes results; the single-pass update (age compares and
// two rate-window products) sets the path between the two registers.
// Synchronous reset clears both valid flags, all supervisor state and loads
// the register defaults. When the receiver stalls, the output register holds
// its word and the input register takes one more event, then req_tready drops.
// ============================================================================
module control_link_safety_supervisor #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   // Event stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [1:0] target_status, [2] resume_value, [7:3] zero
   input  logic [clss_pkg::REQ_DATA_W-1:0]   req_tdata,
   // [2:0] command
   input  logic [clss_pkg::CMD_W-1:0]        req_tuser,
   // Result stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [1:0] mode, [2] send_command, [3] drive, [4] use_velocity,
   // [5] frame_valid, [6] hist_clear, [9:7] degrade_reason,
   // [10] status_changed, [15:11] zero
   output logic [clss_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // Configuration writes
   input  logic                              csr_we,
   input  logic [clss_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [clss_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import clss_pkg::*;

   localparam int RSP_W = $bits(rsp_type);

   cfg_type cfg;
   req_type req_ff, req_in;
   logic    req_valid_ff, req_valid_in;
   rsp_type rsp_ff, rsp_in;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_calc;
   logic    advance;

   clss_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   clss_core #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .req   (req_ff),
      .cfg   (cfg),
      .rsp   (rsp_calc)
   );

   // The held event moves on when the output register is free or draining.
   assign advance    = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || advance;

   // Input register
   always_comb begin
      req_valid_in = req_valid_ff;
      req_in       = req_ff;
      if (req_tready) begin
         req_valid_in         = req_tvalid;
         req_in.command       = req_tuser;
         req_in.target_status = req_tdata[TSTAT_W-1:0];
         req_in.resume_value  = req_tdata[TSTAT_W];
      end
   end

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_in       = rsp_calc;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   // Pack the result word, first field in the lowest bits.
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-RSP_W){1'b0}},
                        rsp_ff.status_changed,
                        rsp_ff.degrade_reason,
                        rsp_ff.hist_clear,
                        rsp_ff.frame_valid,
                        rsp_ff.use_velocity,
                        rsp_ff.drive,
                        rsp_ff.send_command,
                        rsp_ff.mode};

endmodule

FILE: hw/rtl/clss_csr.sv
`timescale 1ns / 1ps
// ============================================================================
// clss_csr
// Configuration registers: timeouts, minimum observation rate and the rate
// window length, written through a plain index/data write port.
// ============================================================================
module clss_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [clss_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [clss_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output clss_pkg::cfg_type                   cfg
);
   import clss_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the write index; unknown indexes are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_SENSOR_TIMEOUT:   cfg_in.sensor_timeout   = csr_wdata;
            REG_TARGET_TIMEOUT:   cfg_in.target_timeout   = csr_wdata;
            REG_VELOCITY_TIMEOUT: cfg_in.velocity_timeout = csr_wdata;
            REG_MIN_OBS_RATE:     cfg_in.min_obs_rate     = csr_wdata[RATE_W-1:0];
            REG_WINDOW_TICKS:     cfg_in.window_ticks     = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sensor_timeout   <= SENSOR_TIMEOUT_RST;
         cfg_ff.target_timeout   <= TARGET_TIMEOUT_RST;
         cfg_ff.velocity_timeout <= VELOCITY_TIMEOUT_RST;
         cfg_ff.min_obs_rate     <= MIN_OBS_RATE_RST;
         cfg_ff.window_ticks     <= WINDOW_TICKS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: hw/rtl/clss_core.sv
`timescale 1ns / 1ps
// ============================================================================
// clss_core
// Supervisor state and its single-pass update: freshness ages, mode and
// reason, and the observation rate window. One event is applied per step.
// ============================================================================
module clss_core #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  clss_pkg::req_type req,
   input  clss_pkg::cfg_type cfg,
   output clss_pkg::rsp_type rsp
);
   import clss_pkg::*;

   localparam int CMP_W  = (COUNT_WIDTH > TIMEOUT_W) ? COUNT_WIDTH : TIMEOUT_W;
   localparam int PROD_W = COUNT_WIDTH + TIMEOUT_W;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
      return (v == COUNT_MAX) ? v : v + 1'b1;
   endfunction

   // State registers
   logic [MODE_W-1:0]      mode_ff, mode_in;
   logic [REASON_W-1:0]    reason_ff, reason_in;
   logic                   have_sensor_ff, have_sensor_in;
   logic                   have_target_ff, have_target_in;
   logic                   have_velocity_ff, have_velocity_in;
   logic [COUNT_WIDTH-1:0] sensor_age_ff, sensor_age_in;
   logic [COUNT_WIDTH-1:0] target_age_ff, target_age_in;
   logic [COUNT_WIDTH-1:0] velocity_age_ff, velocity_age_in;
   logic                   rate_primed_ff, rate_primed_in;
   logic [COUNT_WIDTH-1:0] obs_count_ff, obs_count_in;
   logic [COUNT_WIDTH-1:0] window_elapsed_ff, window_elapsed_in;
   logic [1:0]             slow_count_ff, slow_count_in;

   // Freshness and rate window terms
   logic                   sensor_fresh;
   logic                   target_live;
   logic                   velocity_fresh;
   logic [COUNT_WIDTH-1:0] obs_next;
   logic                   window_closed;
   logic [PROD_W-1:0]      prod_obs;
   logic [PROD_W-1:0]      prod_min;
   logic                   window_slow;
   logic [1:0]             slow_next;

   // Result flags
   logic send_flag, drive_flag, usev_flag, frame_flag, preset_flag;

   assign sensor_fresh   = have_sensor_ff &&
                           (CMP_W'(sensor_age_ff) < CMP_W'(cfg.sensor_timeout));
   assign target_live    = have_target_ff &&
                           (CMP_W'(target_age_ff) < CMP_W'(cfg.target_timeout));
   assign velocity_fresh = have_velocity_ff &&
                           (CMP_W'(velocity_age_ff) < CMP_W'(cfg.velocity_timeout));

   // A window is slow when count * window < rate * elapsed.
   assign obs_next      = sat_inc(obs_count_ff);
   assign window_closed = CMP_W'(window_elapsed_ff) >= CMP_W'(cfg.window_ticks);
   assign prod_obs      = PROD_W'(obs_next) * PROD_W'(cfg.window_ticks);
   assign prod_min      = PROD_W'(cfg.min_obs_rate) * PROD_W'(window_elapsed_ff);
   assign window_slow   = prod_obs < prod_min;
   assign slow_next     = (slow_count_ff == SLOW_COUNT_MAX) ? slow_count_ff
                                                            : slow_count_ff + 2'd1;

   // Event decode and next state
   always_comb begin
      mode_in           = mode_ff;
      reason_in         = reason_ff;
      have_sensor_in    = have_sensor_ff;
      have_target_in    = have_target_ff;
      have_velocity_in  = have_velocity_ff;
      sensor_age_in     = sensor_age_ff;
      target_age_in     = target_age_ff;
      velocity_age_in   = velocity_age_ff;
      rate_primed_in    = rate_primed_ff;
      obs_count_in      = obs_count_ff;
      window_elapsed_in = window_elapsed_ff;
      slow_count_in     = slow_count_ff;
      send_flag         = 1'b0;
      drive_flag        = 1'b0;
      usev_flag         = 1'b0;
      frame_flag        = 1'b0;
      preset_flag       = 1'b0;

      if (step) begin
         unique case (req.command)
            CMD_TICK: begin
               sensor_age_in   = sat_inc(sensor_age_ff);
               target_age_in   = sat_inc(target_age_ff);
               velocity_age_in = sat_inc(velocity_age_ff);
               if (rate_primed_ff) begin
                  window_elapsed_in = sat_inc(window_elapsed_ff);
               end
            end
            CMD_SENSOR: begin
               have_sensor_in = 1'b1;
               sensor_age_in  = '0;
            end
            CMD_TARGET: begin
               if (req.target_status == TSTAT_VALID) begin
                  have_target_in = 1'b1;
                  target_age_in  = '0;
               end else if (req.target_status == TSTAT_NONFINITE &&
                            mode_ff != MODE_DEGRADED) begin
                  mode_in   = MODE_DEGRADED;
                  reason_in = WHY_NONFINITE;
               end
            end
            CMD_VELOCITY: begin
               have_velocity_in = 1'b1;
               velocity_age_in  = '0;
            end
            CMD_RESUME: begin
               if (req.resume_value && mode_ff == MODE_DEGRADED) begin
                  preset_flag    = 1'b1;
                  have_target_in = 1'b0;
                  mode_in        = MODE_WAIT_POLICY;
                  reason_in      = WHY_NONE;
               end
            end
            CMD_OBS_TICK: begin
               if (!sensor_fresh) begin
                  // Stale sensor state: degrade while waiting for a policy or running.
                  if (mode_ff == MODE_WAIT_POLICY || mode_ff == MODE_RUNNING) begin
                     mode_in   = MODE_DEGRADED;
                     reason_in = WHY_SENSOR;
                  end
               end else begin
                  if (mode_ff == MODE_WAIT_SENSOR) begin
                     mode_in = MODE_WAIT_POLICY;
                  end
                  frame_flag = 1'b1;
                  usev_flag  = velocity_fresh;
                  // The first frame only primes the rate window.
                  if (!rate_primed_ff) begin
                     rate_primed_in    = 1'b1;
                     window_elapsed_in = '0;
                     obs_count_in      = '0;
                  end else if (!window_closed) begin
                     obs_count_in = obs_next;
                  end else begin
                     obs_count_in      = '0;
                     window_elapsed_in = '0;
                     if (window_slow && mode_ff == MODE_RUNNING) begin
                        slow_count_in = slow_next;
                        if (slow_next >= SLOW_WINDOW_LIMIT) begin
                           mode_in   = MODE_DEGRADED;
                           reason_in = WHY_RATE;
                        end
                     end else if (!window_slow) begin
                        slow_count_in = '0;
                     end
                  end
               end
            end
            CMD_CMD_TICK: begin
               if (mode_ff == MODE_WAIT_POLICY && target_live) begin
                  mode_in = MODE_RUNNING;
               end else if (mode_ff == MODE_RUNNING && !target_live) begin
                  mode_in   = MODE_DEGRADED;
                  reason_in = WHY_TARGET;
               end
               send_flag  = sensor_fresh;
               drive_flag = sensor_fresh && target_live && (mode_in == MODE_RUNNING);
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff           <= MODE_WAIT_SENSOR;
         reason_ff         <= WHY_NONE;
         have_sensor_ff    <= 1'b0;
         have_target_ff    <= 1'b0;
         have_velocity_ff  <= 1'b0;
         sensor_age_ff     <= '0;
         target_age_ff     <= '0;
         velocity_age_ff   <= '0;
         rate_primed_ff    <= 1'b0;
         obs_count_ff      <= '0;
         window_elapsed_ff <= '0;
         slow_count_ff     <= '0;
      end else begin
         mode_ff           <= mode_in;
         reason_ff         <= reason_in;
         have_sensor_ff    <= have_sensor_in;
         have_target_ff    <= have_target_in;
         have_velocity_ff  <= have_velocity_in;
         sensor_age_ff     <= sensor_age_in;
         target_age_ff     <= target_age_in;
         velocity_age_ff   <= velocity_age_in;
         rate_primed_ff    <= rate_primed_in;
         obs_count_ff      <= obs_count_in;
         window_elapsed_ff <= window_elapsed_in;
         slow_count_ff     <= slow_count_in;
      end
   end

   // Result word for the event being applied
   always_comb begin
      rsp.mode           = mode_in;
      rsp.send_command   = send_flag;
      rsp.drive          = drive_flag;
      rsp.use_velocity   = usev_flag;
      rsp.frame_valid    = frame_flag;
      rsp.hist_clear     = preset_flag;
      rsp.degrade_reason = reason_in;
      rsp.status_changed = (mode_in != mode_ff);
   end

endmodule

FILE: sim/tb_control_link_safety_supervisor.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_control_link_safety_supervisor
// Self-checking testbench for the control link safety supervisor.
//
// An event stream feeds the block, and a scoreboard class predicts the
// result word of every accepted event from its own copy of the mode, ages,
// rate window and register values. Each result word is checked field by
// field against the oldest prediction. A short directed sequence runs under
// the reset register values. Random phases follow, each under its own
// register setting. Some phases hold the result side off for a long stretch.
// Both sides idle at random, with some gap-free stretches.
// ============================================================================
module tb_control_link_safety_supervisor;
   import clss_pkg::*;

   localparam int AGE_W       = 16;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int HOLD_CYCLES = 60;
   localparam int PRINT_LIMIT = 30;

   // Codes that the package leaves unnamed
   localparam logic [CMD_W-1:0]   CMD_UNUSED       = 3'd7;
   localparam logic [TSTAT_W-1:0] TSTAT_BAD_LENGTH = 2'd1;
   localparam logic [TSTAT_W-1:0] TSTAT_RESERVED   = 2'd3;

   // Predicts the result word of every accepted event and checks the block.
   class supervisor_scoreboard;
      logic [TIMEOUT_W-1:0] sensor_limit, target_limit, velocity_limit, window_len;
      logic [RATE_W-1:0]    min_rate;
      logic [MODE_W-1:0]    mode;
      logic [REASON_W-1:0]  reason;
      bit                   sensor_seen, target_seen, velocity_seen, window_armed;
      logic [AGE_W-1:0]     sensor_age, target_age, velocity_age;
      logic [AGE_W-1:0]     obs_count, window_age;
      logic [1:0]           slow_windows;
      rsp_type              expected_status[$];
      int                   errors;
      int                   checked;
      int                   windows_closed;
      bit [7:0]             reasons_seen;
      bit [3:0]             modes_seen;

      function new();
         sensor_limit   = SENSOR_TIMEOUT_RST;
         target_limit   = TARGET_TIMEOUT_RST;
         velocity_limit = VELOCITY_TIMEOUT_RST;
         min_rate       = MIN_OBS_RATE_RST;
         window_len     = WINDOW_TICKS_RST;
         mode           = MODE_WAIT_SENSOR;
         reason         = WHY_NONE;
         sensor_seen    = 0;
         target_seen    = 0;
         velocity_seen  = 0;
         window_armed   = 0;
         sensor_age     = '0;
         target_age     = '0;
         velocity_age   = '0;
         obs_count      = '0;
         window_age     = '0;
         slow_windows   = '0;
         errors         = 0;
         checked        = 0;
         windows_closed = 0;
         reasons_seen   = '0;
         modes_seen     = '0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            REG_SENSOR_TIMEOUT:   sensor_limit   = value;
            REG_TARGET_TIMEOUT:   target_limit   = value;
            REG_VELOCITY_TIMEOUT: velocity_limit = value;
            REG_MIN_OBS_RATE:     min_rate       = value[RATE_W-1:0];
            REG_WINDOW_TICKS:     window_len     = value;
            default: ;
         endcase
      endfunction

      function logic [AGE_W-1:0] bump(logic [AGE_W-1:0] v);
         return (v == '1) ? v : v + 1'b1;
      endfunction

      // The first reason sticks until a resume clears it.
      function void degrade(logic [REASON_W-1:0] why);
         if (mode != MODE_DEGRADED) begin
            mode   = MODE_DEGRADED;
            reason = why;
         end
      endfunction

      // Counts one observation frame and closes the rate window when due.
      function void count_frame();
         bit slow;
         if (!window_armed) begin
            window_armed = 1;
            window_age   = '0;
            obs_count    = '0;
            return;
         end
         obs_count = bump(obs_count);
         if (window_age < window_len) return;
         slow = (longint'(obs_count) * longint'(window_len)) <
                (longint'(min_rate) * longint'(window_age));
         obs_count  = '0;
         window_age = '0;
         windows_closed++;
         if (slow && mode == MODE_RUNNING) begin
            if (slow_windows < SLOW_COUNT_MAX) slow_windows++;
            if (slow_windows >= SLOW_WINDOW_LIMIT) degrade(WHY_RATE);
         end else if (!slow) begin
            slow_windows = '0;
         end
      endfunction

      // Works out the result word of one accepted event.
      function void accept_event(req_type ev);
         rsp_type           st;
         logic [MODE_W-1:0] prior;
         bit                sensor_ok, target_ok;
         st        = '0;
         prior     = mode;
         sensor_ok = sensor_seen && sensor_age < sensor_limit;
         target_ok = target_seen && target_age < target_limit;
         case (ev.command)
            CMD_TICK: begin
               sensor_age   = bump(sensor_age);
               target_age   = bump(target_age);
               velocity_age = bump(velocity_age);
               if (window_armed) window_age = bump(window_age);
            end
            CMD_SENSOR: begin
               sensor_seen = 1;
               sensor_age  = '0;
            end
            CMD_TARGET: begin
               if (ev.target_status == TSTAT_VALID) begin
                  target_seen = 1;
                  target_age  = '0;
               end else if (ev.target_status == TSTAT_NONFINITE) begin
                  degrade(WHY_NONFINITE);
               end
            end
            CMD_VELOCITY: begin
               velocity_seen = 1;
               velocity_age  = '0;
            end
            CMD_RESUME: begin
               if (ev.resume_value && mode == MODE_DEGRADED) begin
                  st.hist_clear = 1'b1;
                  target_seen   = 0;
                  mode          = MODE_WAIT_POLICY;
                  reason        = WHY_NONE;
               end
            end
            CMD_OBS_TICK: begin
               if (!sensor_ok) begin
                  if (mode != MODE_DEGRADED && mode != MODE_WAIT_SENSOR)
                     degrade(WHY_SENSOR);
               end else begin
                  if (mode == MODE_WAIT_SENSOR) mode = MODE_WAIT_POLICY;
                  st.frame_valid  = 1'b1;
                  st.use_velocity = velocity_seen && velocity_age < velocity_limit;
                  count_frame();
               end
            end
            CMD_CMD_TICK: begin
               if (mode == MODE_WAIT_POLICY && target_ok)
                  mode = MODE_RUNNING;
               else if (mode == MODE_RUNNING && !target_ok)
                  degrade(WHY_TARGET);
               st.send_command = sensor_ok;
               st.drive        = sensor_ok && mode == MODE_RUNNING && target_ok;
            end
            default: ;
         endcase
         st.mode           = mode;
         st.degrade_reason = reason;
         st.status_changed = (mode != prior);
         modes_seen[mode]     = 1'b1;
         reasons_seen[reason] = 1'b1;
         expected_status.insert(expected_status.size(), st);
      endfunction

      function void compare(string field, int unsigned want, int unsigned got);
         if (want != got) begin
            errors++;
            if (errors <= PRINT_LIMIT)
               $display("%0t: %s mismatch, expected %0d actual %0d",
                        $time, field, want, got);
         end
      endfunction

      // Checks one result word against the oldest prediction.
      function void check_status(logic [RSP_DATA_W-1:0] word);
         rsp_type want;
         if (expected_status.size() == 0) begin
            errors++;
            if (errors <= PRINT_LIMIT)
               $display("%0t: result word 0x%h arrived, expected none", $time, word);
            return;
         end
         want = expected_status.pop_front();
         checked++;
         compare("mode",           want.mode,           word[1:0]);
         compare("send_command",   want.send_command,   word[2]);
         compare("drive",          want.drive,          word[3]);
         compare("use_velocity",   want.use_velocity,   word[4]);
         compare("frame_valid",    want.frame_valid,    word[5]);
         compare("hist_clear",     want.hist_clear,     word[6]);
         compare("degrade_reason", want.degrade_reason, word[9:7]);
         compare("status_changed", want.status_changed, word[10]);
         compare("padding",        0,                   word[15:11]);
      endfunction
   endclass

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [CMD_W-1:0]      req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   supervisor_scoreboard sb;
   bit calm          = 0;
   int hold_requests = 0;
   int holds_served  = 0;
   int stall_left    = 0;
   int events_sent   = 0;
   int settings_used = 1;
   int cycle_count   = 0;

   control_link_safety_supervisor u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("tb_control_link_safety_supervisor NOT OK");
         $finish;
      end
   end

   // Result side: check each accepted word, then pick the next ready level.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) sb.check_status(rsp_tdata);
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (holds_served != hold_requests) begin
            holds_served++;
            stall_left = HOLD_CYCLES - 1;
            rsp_tready <= 1'b0;
         end else if (calm) begin
            rsp_tready <= 1'b1;
         end else begin
            case ($urandom_range(0, 19)) inside
               [0:4]: begin
                  stall_left = $urandom_range(0, 2);
                  rsp_tready <= 1'b0;
               end
               5: begin
                  stall_left = $urandom_range(8, 30);
                  rsp_tready <= 1'b0;
               end
               default: rsp_tready <= 1'b1;
            endcase
         end
      end
   end

   // Gap before the next event word: mostly none or short, now and then long.
   function int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(6, 25);
   endfunction

   // Offers one event word and waits until the block takes it.
   task automatic send_event(input logic [CMD_W-1:0] cmd,
                             input logic [TSTAT_W-1:0] tstat, input logic rval);
      int      gap;
      req_type ev;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      ev.command       = cmd;
      ev.target_status = tstat;
      ev.resume_value  = rval;
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {{(REQ_DATA_W-3){1'b0}}, rval, tstat};
      do @(posedge clock); while (!req_tready);
      sb.accept_event(ev);
      events_sent++;
   endtask

   task automatic send_ticks(input int count);
      repeat (count) send_event(CMD_TICK, 2'($urandom), 1'($urandom));
   endtask

   // One event from a plausible control loop; unused fields carry noise.
   task automatic send_random_event();
      int                 r;
      logic [TSTAT_W-1:0] noise;
      logic [TSTAT_W-1:0] tstat;
      r     = $urandom_range(0, 99);
      noise = 2'($urandom);
      case ($urandom_range(0, 99)) inside
         [0:84]:  tstat = TSTAT_VALID;
         [85:91]: tstat = TSTAT_BAD_LENGTH;
         [92:96]: tstat = TSTAT_NONFINITE;
         default: tstat = TSTAT_RESERVED;
      endcase
      if (r < 5)
         send_ticks($urandom_range(3, 20));
      else if (r < 30)
         send_event(CMD_TICK, noise, 1'($urandom));
      else if (r < 44)
         send_event(CMD_SENSOR, noise, 1'($urandom));
      else if (r < 56)
         send_event(CMD_TARGET, tstat, 1'($urandom));
      else if (r < 64)
         send_event(CMD_VELOCITY, noise, 1'($urandom));
      else if (r < 69)
         send_event(CMD_RESUME, noise, $urandom_range(0, 4) != 0);
      else if (r < 84)
         send_event(CMD_OBS_TICK, noise, 1'($urandom));
      else
         send_event(CMD_CMD_TICK, noise, 1'($urandom));
   endtask

   // Stops offering and waits until every predicted word has come back.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (sb.expected_status.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      sb.set_reg(idx, value);
   endtask

   // Drains the block, loads a register setting and runs random events.
   task automatic run_phase(input int sensor_to, input int target_to,
                            input int velocity_to, input int rate, input int win,
                            input int count, input int calm_count,
                            input bit long_hold);
      settle();
      write_reg(REG_SENSOR_TIMEOUT, CSR_DATA_W'(sensor_to));
      write_reg(REG_TARGET_TIMEOUT, CSR_DATA_W'(target_to));
      write_reg(REG_VELOCITY_TIMEOUT, CSR_DATA_W'(velocity_to));
      write_reg(REG_MIN_OBS_RATE, CSR_DATA_W'(rate));
      write_reg(REG_WINDOW_TICKS, CSR_DATA_W'(win));
      csr_we <= 1'b0;
      settings_used++;
      if (long_hold) hold_requests++;
      for (int i = 0; i < count; i++) begin
         calm = (i < calm_count);
         send_random_event();
      end
      calm = 0;
   endtask

   initial begin
      sb = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed walk through the modes under the reset register values.
      send_event(CMD_UNUSED, TSTAT_RESERVED, 1'b1);
      send_event(CMD_OBS_TICK, TSTAT_VALID, 1'b0);
      send_event(CMD_CMD_TICK, TSTAT_VALID, 1'b0);
      send_event(CMD_SENSOR, TSTAT_VALID, 1'b0);
      send_event(CMD_CMD_TICK, TSTAT_VALID, 1'b0);
      send_event(CMD_OBS_TICK, TSTAT_VALID, 1'b0);
      send_event(CMD_VELOCITY, TSTAT_VALID, 1'b0);
      send_event(CMD_OBS_TICK, TSTAT_VALID, 1'b0);
      send_event(CMD_TARGET, TSTAT_BAD_LENGTH, 1'b0);
      send_event(CMD_TARGET, TSTAT_RESERVED, 1'b0);
      send_event(CMD_CMD_TICK, TSTAT_VALID, 1'b0);
      send_event(CMD_TARGET, TSTAT_VALID, 1'b0);
      send_event(CMD_TICK, TSTAT_VALID, 1'b0);
      send_event(CMD_CMD_TICK, TSTAT_VALID, 1'b0);
      // Resume while running is ignored; a bad target degrades once.
      send_event(CMD_RESUME, TSTAT_VALID, 1'b1);
      send_event(CMD_TARGET, TSTAT_NONFINITE, 1'b0);
      send_event(CMD_TARGET, TSTAT_NONFINITE, 1'b0);
      send_event(CMD_OBS_TICK, TSTAT_VALID, 1'b0);
      send_event(CMD_RESUME, TSTAT_VALID, 1'b0);
      send_event(CMD_RESUME, TSTAT_VALID, 1'b1);
      send_event(CMD_CMD_TICK, TSTAT_VALID, 1'b0);
      send_event(CMD_TICK, TSTAT_VALID, 1'b0);

      // Random phases under fixed settings, then under random settings.
      run_phase(6, 4, 3, 0, 1, 70, 0, 0);
      run_phase(1, 1, 1, 1000, 4, 60, 20, 0);
      run_phase(12, 10, 65535, 600, 6, 80, 0, 1);
      run_phase(65535, 65535, 8, 1000, 3, 70, 0, 0);

      run_phase($urandom_range(1, 40), $urandom_range(1, 30), $urandom_range(1, 30),
                $urandom_range(0, 1000), $urandom_range(1, 12), 60, 25, 0);
      run_phase($urandom_range(1, 40), $urandom_range(1, 30), $urandom_range(1, 30),
                $urandom_range(0, 1000), $urandom_range(1, 12), 50, 0, 1);
      settle();

      $display("Sent %0d events under %0d register settings, checked %0d result words,",
               events_sent, settings_used, sb.checked);
      $display("closed %0d rate windows; reasons seen %b, modes seen %b.",
               sb.windows_closed, sb.reasons_seen[4:0], sb.modes_seen);
      if (sb.errors == 0 && sb.expected_status.size() == 0) begin
         $display("tb_control_link_safety_supervisor OK");
      end else begin
         $display("%0d mismatches", sb.errors);
         $display("tb_control_link_safety_supervisor NOT OK");
      end
      $finish;
   end

endmodule

FILE: control_link_safety_supervisor.f
hw/rtl/clss_pkg.sv
hw/rtl/clss_csr.sv
hw/rtl/clss_core.sv
hw/rtl/control_link_safety_supervisor.sv
sim/tb_control_link_safety_supervisor.sv
